[rtl/tlpq_pkg.sv]
// tlpq_pkg: shared types and constants of the three level priority fifo
// no dependencies; compiled before every other file of the block
package tlpq_pkg;

    localparam int CAP_W     = 5;
    localparam int NUM_CAP   = 3;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int PRIO_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPRIO  = 3'd4;

    localparam logic [1:0] REG_L1_CAP = 2'd0;
    localparam logic [1:0] REG_L2_CAP = 2'd1;
    localparam logic [1:0] REG_L3_CAP = 2'd2;

    typedef logic [CAP_W-1:0] cap_t;

    typedef struct packed {
        logic accept;
        logic load_data;
    } tlpq_cmd_t;

    typedef struct packed {
        logic deq_hit;
    } tlpq_stat_t;

endpackage

[rtl/tlpq_if.sv]
// tlpq_in_if, tlpq_out_if: valid/ready channels for request and result beats
// depends on tlpq_pkg
interface tlpq_in_if
    import tlpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [WORD_W-1:0] data_in;
    logic [PRIO_W-1:0]        priority_req;

    modport source (output valid, output opcode, output data_in, output priority_req,
                    input ready);
    modport sink   (input valid, input opcode, input data_in, input priority_req,
                    output ready);
endinterface

interface tlpq_out_if
    import tlpq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data_out;
    logic [PRIO_W-1:0]        served_level;

    modport source (output valid, output status, output data_out, output served_level,
                    input ready);
    modport sink   (input valid, input status, input data_out, input served_level,
                    output ready);
endinterface

[rtl/three_level_priority_fifo_top.sv]
// three level strict priority fifo: enqueue and dequeue requests, one result each
// request beats on in_ch, result beats on out_ch, capacity registers over apb
// an enqueue stores a signed word in the fifo of levels 1 to 3 (1 highest),
// or is refused as full or as an invalid priority; a dequeue returns the
// oldest word of the highest non-empty level, or an all-empty status
// one request is in flight at a time: in_ch.ready is high only while no
// result is pending
// the result is registered and shown in S_RESP; a dequeue that finds an entry
// first passes through S_READ (registered read of the entry ram), so that
// every request is answered with a result beat before the next request
// is taken
// a stall on out_ch holds the result and keeps in_ch.ready low
// reset empties all levels and sets every capacity to 16; capacity
// registers at byte addresses 0, 4, 8, pready always high
// depends on tlpq_pkg, tlpq_if, tlpq_regs, tlpq_ctrl, tlpq_datapath
module three_level_priority_fifo_top
    import tlpq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int LEVELS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    tlpq_in_if.sink            in_ch,
    tlpq_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cap_t       cap [NUM_CAP];
    tlpq_cmd_t  cmd;
    tlpq_stat_t stat;

    tlpq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cap     (cap)
    );

    tlpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlpq_datapath #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cap          (cap),
        .opcode       (in_ch.opcode),
        .data_in      (in_ch.data_in),
        .priority_req (in_ch.priority_req),
        .status       (out_ch.status),
        .data_out     (out_ch.data_out),
        .served_level (out_ch.served_level)
    );

endmodule

[rtl/tlpq_ram.sv]
// tlpq_ram: generic single write port, single read port ram, registered read
// no dependencies
module tlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlpq_regs.sv]
// tlpq_regs: apb capacity registers, one per priority level
// depends on tlpq_pkg
module tlpq_regs
    import tlpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cap_t               cap [NUM_CAP]
);

    cap_t       cap_reg [NUM_CAP];
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAP; i++)
            begin
                cap_reg[i] <= CAP_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_L1_CAP: cap_reg[0] <= pwdata[CAP_W-1:0];
                REG_L2_CAP: cap_reg[1] <= pwdata[CAP_W-1:0];
                REG_L3_CAP: cap_reg[2] <= pwdata[CAP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_L1_CAP: prdata = PDATA_W'(cap_reg[0]);
            REG_L2_CAP: prdata = PDATA_W'(cap_reg[1]);
            REG_L3_CAP: prdata = PDATA_W'(cap_reg[2]);
            default:    prdata = '0;
        endcase
    end

    assign cap = cap_reg;

endmodule

[rtl/tlpq_ctrl.sv]
// tlpq_ctrl: request/result sequencing state machine
// depends on tlpq_pkg; drives the datapath through tlpq_cmd_t
module tlpq_ctrl
    import tlpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  tlpq_stat_t stat,
    output tlpq_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_RESP);
    assign accept        = in_valid & in_ready;
    assign cmd.accept    = accept;
    assign cmd.load_data = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.deq_hit ? S_READ : S_RESP;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while a result is pending");

    a_deq_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.deq_hit) |=> (state_reg == S_READ))
        else $error("dequeue hit did not start a ram read");

    a_read_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid)
        else $error("ram read not followed by a result beat");
`endif

endmodule

[rtl/tlpq_datapath.sv]
// tlpq_datapath: per level pointers and counts, entry ram, result registers
// depends on tlpq_pkg and tlpq_ram; commanded by tlpq_ctrl
module tlpq_datapath
    import tlpq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int LEVELS = 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tlpq_cmd_t                cmd,
    output tlpq_stat_t               stat,
    input  cap_t                     cap [NUM_CAP],
    input  logic                     opcode,
    input  logic signed [WORD_W-1:0] data_in,
    input  logic [PRIO_W-1:0]        priority_req,
    output logic [STATUS_W-1:0]      status,
    output logic signed [WORD_W-1:0] data_out,
    output logic [PRIO_W-1:0]        served_level
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOTS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [OCC_W-1:0] occ_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [OCC_W-1:0] occ_next  [LEVELS];
    logic [CMP_W-1:0] eff_cap  [LEVELS];

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [PRIO_W-1:0]   level_reg;
    logic [PRIO_W-1:0]   level_next;
    logic [WORD_W-1:0]   dout_reg;

    logic              is_enq;
    logic              prio_ok;
    logic              full;
    logic              deq_hit;
    logic [LVL_W-1:0]  enq_lvl;
    logic [LVL_W-1:0]  deq_lvl;
    logic              enq_do;
    logic              deq_do;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_cap
        logic [CMP_W-1:0] raw;
        if (l < NUM_CAP)
        begin : g_reg
            assign raw = CMP_W'(cap[l]);
        end
        else
        begin : g_fixed
            assign raw = CMP_W'(DEPTH);
        end
        assign eff_cap[l] = (raw == '0) ? CMP_W'(1)
                          : ((raw > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : raw);
    end

    assign is_enq  = (opcode == OP_ENQ);
    assign prio_ok = (priority_req != '0) && (32'(priority_req) <= LEVELS);
    assign enq_lvl = LVL_W'(priority_req - 2'd1);
    assign full    = CMP_W'(occ_reg[enq_lvl]) >= eff_cap[enq_lvl];

    always_comb
    begin
        deq_hit = 1'b0;
        deq_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (occ_reg[l] != '0)
            begin
                deq_hit = 1'b1;
                deq_lvl = LVL_W'(l);
            end
        end
    end

    assign enq_do       = cmd.accept & is_enq & prio_ok & ~full;
    assign deq_do       = cmd.accept & ~is_enq & deq_hit;
    assign stat.deq_hit = ~is_enq & deq_hit;

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            tail_next[l] = tail_reg[l];
            occ_next[l]  = occ_reg[l];
            if (enq_do && (enq_lvl == LVL_W'(l)))
            begin
                tail_next[l] = (tail_reg[l] == PTR_W'(DEPTH - 1)) ? '0
                             : tail_reg[l] + PTR_W'(1);
                occ_next[l]  = occ_reg[l] + OCC_W'(1);
            end
            if (deq_do && (deq_lvl == LVL_W'(l)))
            begin
                head_next[l] = (head_reg[l] == PTR_W'(DEPTH - 1)) ? '0
                             : head_reg[l] + PTR_W'(1);
                occ_next[l]  = occ_reg[l] - OCC_W'(1);
            end
        end
    end

    always_comb
    begin
        status_next = ST_EMPTY;
        level_next  = '0;
        if (is_enq)
        begin
            if (!prio_ok)
            begin
                status_next = ST_BADPRIO;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_ENQUEUED;
                level_next  = priority_req;
            end
        end
        else if (deq_hit)
        begin
            status_next = ST_DEQUEUED;
            level_next  = PRIO_W'(32'(deq_lvl) + 1);
        end
    end

    assign waddr = ADDR_W'(32'(enq_lvl) * DEPTH) + ADDR_W'(tail_reg[enq_lvl]);
    assign raddr = ADDR_W'(32'(deq_lvl) * DEPTH) + ADDR_W'(head_reg[deq_lvl]);

    tlpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (enq_do),
        .waddr (waddr),
        .wdata (data_in),
        .re    (deq_do),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                occ_reg[l]  <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
            dout_reg   <= '0;
        end
        else if (cmd.load_data)
        begin
            dout_reg <= rdata;
        end
    end

    assign status       = status_reg;
    assign served_level = level_reg;
    assign data_out     = dout_reg;

`ifndef ASSERT_OFF
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_chk
        a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
            32'(occ_reg[l]) <= DEPTH)
            else $error("level count beyond depth");
    end
`endif

endmodule

[verif/tlpq_result_checker.sv]
// tlpq_result_checker: tracks the three level priority fifo beat by beat, predicts
// the result of every request beat and compares each result beat field by field
// depends on tlpq_pkg and the tlpq_in_if / tlpq_out_if interfaces
`timescale 1ns / 100ps

module tlpq_result_checker
    import tlpq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int LEVELS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    tlpq_in_if                 req_ch,
    tlpq_out_if                res_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 pending_results,
    output int                 fail_count
);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data_out;
        logic [PRIO_W-1:0]        served_level;
    } fifo_result_t;

    cap_t              level_cap  [LEVELS];
    logic [WORD_W-1:0] slot_word  [LEVELS][DEPTH];
    int                head_slot  [LEVELS];
    int                tail_slot  [LEVELS];
    int                fill_count [LEVELS];
    fifo_result_t      expected_results [$];
    fifo_result_t      want;
    int                reg_idx;

    initial fail_count = 0;

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic fifo_result_t serve_request(logic op, logic [WORD_W-1:0] word,
                                                   logic [PRIO_W-1:0] prio);
        fifo_result_t r;
        int           lvl;
        int           usable;
        r.status       = ST_EMPTY;
        r.data_out     = '0;
        r.served_level = '0;
        if (op == OP_ENQ)
        begin
            if (prio == 0 || prio > LEVELS)
            begin
                r.status = ST_BADPRIO;
            end
            else
            begin
                lvl = int'(prio) - 1;
                // zero acts as one entry, anything above the depth as the depth
                usable = (level_cap[lvl] == 0) ? 1 :
                         (level_cap[lvl] > DEPTH) ? DEPTH : int'(level_cap[lvl]);
                if (fill_count[lvl] >= usable)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot_word[lvl][tail_slot[lvl]] = word;
                    tail_slot[lvl]  = (tail_slot[lvl] + 1) % DEPTH;
                    fill_count[lvl] = fill_count[lvl] + 1;
                    r.status        = ST_ENQUEUED;
                    r.served_level  = prio;
                end
            end
        end
        else
        begin
            for (lvl = 0; lvl < LEVELS; lvl++)
            begin
                if (r.status == ST_EMPTY && fill_count[lvl] != 0)
                begin
                    r.data_out      = slot_word[lvl][head_slot[lvl]];
                    head_slot[lvl]  = (head_slot[lvl] + 1) % DEPTH;
                    fill_count[lvl] = fill_count[lvl] - 1;
                    r.status        = ST_DEQUEUED;
                    r.served_level  = PRIO_W'(lvl + 1);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                level_cap[i]  = CAP_RESET;
                head_slot[i]  = 0;
                tail_slot[i]  = 0;
                fill_count[i] = 0;
            end
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result beat with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  res_ch.status, want.status));
                    if (res_ch.data_out !== want.data_out)
                        report_mismatch($sformatf("data_out %0d, expected %0d",
                                                  res_ch.data_out, want.data_out));
                    if (res_ch.served_level !== want.served_level)
                        report_mismatch($sformatf("served_level %0d, expected %0d",
                                                  res_ch.served_level, want.served_level));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = int'(paddr[PADDR_W-1:2]);
                if (reg_idx < NUM_CAP)
                    level_cap[reg_idx] = pwdata[CAP_W-1:0];
            end
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(serve_request(req_ch.opcode, req_ch.data_in,
                                                         req_ch.priority_req));
            pending_results <= expected_results.size();
        end
    end

endmodule

[verif/tb_top.sv]
// tb_top: drives request beats and capacity writes into three_level_priority_fifo_top
// with random gaps and result stalls; the checker beside it predicts and compares
// depends on tlpq_pkg, tlpq_if, the block's rtl and tlpq_result_checker
`timescale 1ns / 100ps

module tb_top;
    import tlpq_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending_results;
    int                 fail_count;
    int                 long_hold_cycles;
    bit                 steady_flow;

    tlpq_in_if  req_ch ();
    tlpq_out_if res_ch ();

    three_level_priority_fifo_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tlpq_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_ch          (req_ch),
        .res_ch          (res_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("** three_level_priority_fifo_top: FAILED **");
        $finish;
    end

    // result side: random stall before each beat unless steady flow is set, or one long hold when asked
    initial
    begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_cycles != 0)
            begin
                stall = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
            begin
                stall = steady_flow ? 0 : $urandom_range(0, 8);
            end
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_request(logic op, logic [WORD_W-1:0] word, logic [PRIO_W-1:0] prio);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.data_in      <= word;
        req_ch.priority_req <= prio;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_capacities(cap_t cap1, cap_t cap2, cap_t cap3);
        drain_results();
        apb_write(REG_L1_CAP, PDATA_W'(cap1));
        apb_write(REG_L2_CAP, PDATA_W'(cap2));
        apb_write(REG_L3_CAP, PDATA_W'(cap3));
        apb_write(REG_UNMAPPED, $urandom());
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                phase;
        int                n;
        int                enq_pct;
        logic              op;
        logic [PRIO_W-1:0] prio;
        logic [WORD_W-1:0] word;

        long_hold_cycles = 0;
        steady_flow      = 1'b0;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_ENQ;
        req_ch.data_in      <= '0;
        req_ch.priority_req <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_DEQ, 32'hFFFF_FFFF, 2'd0);
        send_request(OP_ENQ, 32'h1234_5678, 2'd0);
        set_capacities(5'd0, 5'd31, 5'd1);
        send_request(OP_ENQ, 32'h7FFF_FFFF, 2'd1);
        send_request(OP_ENQ, 32'h8000_0000, 2'd1);
        send_request(OP_ENQ, 32'hFFFF_FFFF, 2'd3);
        send_request(OP_ENQ, 32'h0000_0000, 2'd3);
        send_request(OP_ENQ, 32'h5555_5555, 2'd2);
        send_request(OP_ENQ, 32'hAAAA_AAAA, 2'd2);
        send_request(OP_ENQ, 32'h0000_0001, 2'd2);
        repeat (6) send_request(OP_DEQ, $urandom(), 2'($urandom_range(0, 3)));

        // capacity lowered under the current fill of level 2
        set_capacities(CAP_RESET, CAP_RESET, CAP_RESET);
        repeat (4) send_request(OP_ENQ, $urandom(), 2'd2);
        set_capacities(CAP_RESET, 5'd2, CAP_RESET);
        send_request(OP_ENQ, $urandom(), 2'd2);
        send_request(OP_DEQ, $urandom(), 2'd1);
        send_request(OP_ENQ, $urandom(), 2'd2);
        repeat (2) send_request(OP_DEQ, $urandom(), 2'd3);
        send_request(OP_ENQ, $urandom(), 2'd2);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_capacities(5'd1, 5'd1, 5'd1);
                1: set_capacities(5'd31, 5'd0, 5'd17);
                2: set_capacities(CAP_RESET, CAP_RESET, CAP_RESET);
                default: set_capacities(cap_t'($urandom_range(0, 31)),
                                        cap_t'($urandom_range(0, 31)),
                                        cap_t'($urandom_range(0, 31)));
            endcase
            steady_flow = (phase % 3 == 2);
            if (phase == 2)
                long_hold_cycles = 150;
            for (n = 0; n < 100; n++)
            begin
                // swing between filling and draining so levels hit full and empty
                if (n % 25 == 0)
                    enq_pct = $urandom_range(15, 85);
                op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                prio = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                case ($urandom_range(0, 7))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    default: word = $urandom();
                endcase
                send_request(op, word, prio);
            end
        end
        steady_flow = 1'b0;

        drain_results();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("** three_level_priority_fifo_top: PASSED **");
        else
            $display("** three_level_priority_fifo_top: FAILED **");
        $finish;
    end

endmodule
